FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands for the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on every rising edge outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  `ASSERT_CLKD(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

FILE: rtl/tmrb_pkg.sv
// ---------------------------------------------------------------------------
// tmrb_pkg
// types, constants and helpers for the transmit message ring buffer
// ---------------------------------------------------------------------------
package tmrb_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned OCC_W  = $clog2(DEPTH + 1);
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 8;
  localparam int unsigned CMP_W  = (OCC_W > LEN_W) ? OCC_W : LEN_W;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = 16;

  // request function codes
  localparam logic FN_STORE = 1'b0;
  localparam logic FN_READY = 1'b1;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [OCC_W-1:0]  occ_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [CMP_W-1:0]  cmp_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_LENGTH = 2'd1,
    ST_NO_ROOM    = 2'd2,
    ST_DROPPED    = 2'd3
  } status_e;

  // wraps at DEPTH, also for depths that are not a power of two
  function automatic ptr_t ptr_next(ptr_t p);
    ptr_t r;
    if (p == ptr_t'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

FILE: rtl/tmrb_ram.sv
// ---------------------------------------------------------------------------
// tmrb_ram
// generic single-write, single-read ram with registered read data
// ---------------------------------------------------------------------------
module tmrb_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/tx_message_ring_buffer_unit.sv
// ---------------------------------------------------------------------------
// tx_message_ring_buffer_unit: transmit ring buffer for whole messages
// result path: ram read into the pending stage, then the output register
// throughput: one request per cycle while the result side keeps up
// reset: pointers, occupancy and flags clear at once; ring contents stay undefined
// ---------------------------------------------------------------------------
module tx_message_ring_buffer_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [7:0] data_byte, [15:8] msg_length
  input  logic [tmrb_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // [0] func, [1] first_of_message
  input  logic [tmrb_pkg::IN_TUSER_W-1:0]   s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [1:0] status, [2] tx_valid, [10:3] tx_byte, [11] busy_res, [15:12] zero
  output logic [tmrb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);

  // request fields
  logic             in_func;
  logic             in_first;
  tmrb_pkg::byte_t  in_data;
  tmrb_pkg::len_t   in_len;

  assign in_func  = s_axis_tuser_i[0];
  assign in_first = s_axis_tuser_i[1];
  assign in_data  = s_axis_tdata_i[7:0];
  assign in_len   = s_axis_tdata_i[15:8];

  // control state
  tmrb_pkg::ptr_t wr_ptr_q, wr_ptr_d;
  tmrb_pkg::ptr_t rd_ptr_q, rd_ptr_d;
  tmrb_pkg::occ_t occ_q, occ_d;
  logic           busy_q, busy_d;
  tmrb_pkg::len_t bts_q, bts_d;
  logic           drop_q, drop_d;

  logic              accept;
  logic              store;
  logic              emit;
  tmrb_pkg::status_e status;

  // pending stage, waiting for ram read data
  logic              pend_q;
  logic              pend_move;
  logic              pend_emit_q;
  logic              pend_fwd_q;
  tmrb_pkg::byte_t   pend_byte_q;
  tmrb_pkg::status_e pend_status_q;
  logic              pend_busy_q;

  // output register
  logic                                 out_valid_q;
  logic [tmrb_pkg::OUT_TDATA_W-1:0]     out_tdata_q;

  tmrb_pkg::byte_t ram_rdata;
  tmrb_pkg::byte_t tx_byte;

  assign pend_move       = pend_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !pend_q || pend_move;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    busy_d   = busy_q;
    bts_d    = bts_q;
    drop_d   = drop_q;
    store    = 1'b0;
    emit     = 1'b0;
    status   = tmrb_pkg::ST_OK;

    if (in_func == tmrb_pkg::FN_READY) begin
      if (busy_q) begin
        if (occ_q != '0) begin
          emit = 1'b1;
        end else begin
          busy_d = 1'b0;
        end
      end
    end else if (in_first) begin
      if (in_len == '0 ||
          tmrb_pkg::cmp_t'(in_len) > tmrb_pkg::cmp_t'(tmrb_pkg::DEPTH)) begin
        status = tmrb_pkg::ST_BAD_LENGTH;
        bts_d  = '0;
        drop_d = 1'b1;
      end else if (tmrb_pkg::cmp_t'(in_len) >
                   tmrb_pkg::cmp_t'(tmrb_pkg::DEPTH) - tmrb_pkg::cmp_t'(occ_q)) begin
        status = tmrb_pkg::ST_NO_ROOM;
        bts_d  = '0;
        drop_d = 1'b1;
      end else begin
        drop_d = 1'b0;
        store  = 1'b1;
        bts_d  = in_len - 1'b1;
      end
    end else if (bts_q != '0 && !drop_q) begin
      if (tmrb_pkg::cmp_t'(occ_q) >= tmrb_pkg::cmp_t'(tmrb_pkg::DEPTH)) begin
        status = tmrb_pkg::ST_NO_ROOM;
        bts_d  = '0;
        drop_d = 1'b1;
      end else begin
        store = 1'b1;
        bts_d = bts_q - 1'b1;
      end
    end else begin
      status = tmrb_pkg::ST_DROPPED;
    end

    // message complete and transmitter idle: start sending
    if (store && bts_d == '0 && !busy_q) begin
      emit   = 1'b1;
      busy_d = 1'b1;
    end

    if (store) begin
      wr_ptr_d = tmrb_pkg::ptr_next(wr_ptr_q);
    end
    if (emit) begin
      rd_ptr_d = tmrb_pkg::ptr_next(rd_ptr_q);
    end
    occ_d = occ_q + tmrb_pkg::occ_t'(store) - tmrb_pkg::occ_t'(emit);
  end

  tmrb_ram #(
    .WIDTH (tmrb_pkg::BYTE_W),
    .DEPTH (tmrb_pkg::DEPTH),
    .ADDR_W(tmrb_pkg::PTR_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (accept && store),
    .waddr_i(wr_ptr_q),
    .wdata_i(in_data),
    .re_i   (accept && emit),
    .raddr_i(rd_ptr_q),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      occ_q       <= '0;
      busy_q      <= 1'b0;
      bts_q       <= '0;
      drop_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        wr_ptr_q <= wr_ptr_d;
        rd_ptr_q <= rd_ptr_d;
        occ_q    <= occ_d;
        busy_q   <= busy_d;
        bts_q    <= bts_d;
        drop_q   <= drop_d;
      end
      if (accept) begin
        pend_q <= 1'b1;
      end else if (pend_move) begin
        pend_q <= 1'b0;
      end
      if (pend_move) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ram is read-first: a byte written and sent in the same request is forwarded
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_emit_q   <= emit;
      pend_fwd_q    <= store && emit && (wr_ptr_q == rd_ptr_q);
      pend_byte_q   <= in_data;
      pend_status_q <= status;
      pend_busy_q   <= busy_d;
    end
    if (pend_move) begin
      out_tdata_q <= {4'b0000, pend_busy_q, tx_byte, pend_emit_q, pend_status_q};
    end
  end

  always_comb begin
    if (!pend_emit_q) begin
      tx_byte = '0;
    end else if (pend_fwd_q) begin
      tx_byte = pend_byte_q;
    end else begin
      tx_byte = ram_rdata;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_tdata_q;

endmodule

FILE: rtl/tmrb_checker.sv
// ---------------------------------------------------------------------------
// tmrb_checker
// port-level checks on the result stream of the ring buffer
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tmrb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_tvalid_i,
  input logic        m_tready_i,
  input logic [15:0] m_tdata_i
);

  logic [1:0] res_status;
  logic       res_tx_valid;
  logic [7:0] res_tx_byte;
  logic       res_busy;

  assign res_status   = m_tdata_i[1:0];
  assign res_tx_valid = m_tdata_i[2];
  assign res_tx_byte  = m_tdata_i[10:3];
  assign res_busy     = m_tdata_i[11];

  `ASSERT_CLKD(a_out_hold, clk_i, rst_ni, m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i), "result changed while stalled")
  `ASSERT_IMPL(a_idle_byte_zero, clk_i, rst_ni, m_tvalid_i && !res_tx_valid, res_tx_byte == 8'd0, "byte set without tx_valid")
  `ASSERT_IMPL(a_send_busy, clk_i, rst_ni, m_tvalid_i && res_tx_valid, res_busy, "byte sent while transmitter idle")
  `ASSERT_IMPL(a_err_no_send, clk_i, rst_ni, m_tvalid_i && res_status != tmrb_pkg::ST_OK, !res_tx_valid, "byte sent on a rejected request")

endmodule

bind tx_message_ring_buffer_unit tmrb_checker u_tmrb_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .m_tvalid_i(m_axis_tvalid_o),
  .m_tready_i(m_axis_tready_i),
  .m_tdata_i (m_axis_tdata_o)
);
